[design/ptt_pkg.sv]
// Package for the periodic timer table: table entry type, table port request,
// unit, status and action codes, and width constants. No dependencies.
package ptt_pkg;

	localparam int MAX_TIMERS = 16;
	localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 80;
	localparam int SCALE_W    = 17;
	localparam int PROD_W     = 16 + SCALE_W;
	localparam int DUE_W      = PROD_W + 1;

	localparam logic [2:0] UNIT_10MS = 3'd0;
	localparam logic [2:0] UNIT_MIN  = 3'd2;
	localparam logic [2:0] UNIT_HOUR = 3'd3;
	localparam logic [2:0] UNIT_DAY  = 3'd4;

	localparam logic [SCALE_W-1:0] SCALE_SEC  = SCALE_W'(1);
	localparam logic [SCALE_W-1:0] SCALE_MIN  = SCALE_W'(60);
	localparam logic [SCALE_W-1:0] SCALE_HOUR = SCALE_W'(3600);
	localparam logic [SCALE_W-1:0] SCALE_DAY  = SCALE_W'(86400);

	localparam logic [2:0] ST_FIRED     = 3'd0;
	localparam logic [2:0] ST_TICK_DONE = 3'd1;
	localparam logic [2:0] ST_ADDED     = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_DELETED   = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_DEL    = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] start;
		logic [15:0] interval;
		logic [2:0]  unit;
		logic [7:0]  dest;
		logic [15:0] msg;
	} ptt_entry_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} ptt_tbl_req_t;

endpackage

[design/ptt_table.sv]
// Timer entry memory: one write port and one registered read port.
// Depends on ptt_pkg for the entry type, the request struct and the depth.
module ptt_table (
	input  logic                 clk,
	input  ptt_pkg::ptt_tbl_req_t req,
	input  ptt_pkg::ptt_entry_t  wr_data,
	output ptt_pkg::ptt_entry_t  rd_data
);

	ptt_pkg::ptt_entry_t mem [ptt_pkg::MAX_TIMERS];
	ptt_pkg::ptt_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[design/ptt_due.sv]
// Shared due-time unit: registers interval times unit scale, then adds the
// start time and compares against the current time. Depends on ptt_pkg.
module ptt_due (
	input  logic        clk,
	input  logic        load,
	input  logic [15:0] interval,
	input  logic [2:0]  unit,
	input  logic [31:0] start,
	input  logic [31:0] now,
	output logic        hit
);

	logic [ptt_pkg::SCALE_W-1:0] scale;
	logic [ptt_pkg::PROD_W-1:0]  prod_q;
	logic [ptt_pkg::DUE_W-1:0]   due;

	always_comb begin
		unique case (unit)
			ptt_pkg::UNIT_MIN:  scale = ptt_pkg::SCALE_MIN;
			ptt_pkg::UNIT_HOUR: scale = ptt_pkg::SCALE_HOUR;
			ptt_pkg::UNIT_DAY:  scale = ptt_pkg::SCALE_DAY;
			default:            scale = ptt_pkg::SCALE_SEC;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= ptt_pkg::PROD_W'(interval) * ptt_pkg::PROD_W'(scale);
		end
	end

	assign due = ptt_pkg::DUE_W'(start) + ptt_pkg::DUE_W'(prod_q);
	assign hit = ptt_pkg::DUE_W'(now) >= due;

endmodule

[design/periodic_timer_table_top.sv]
// Top level of the periodic timer table: input latch, sequencer, output
// register. Depends on ptt_pkg, ptt_table and ptt_due.
// Add: writes the entry unless full, then the result. Delete: searches entries
// in turn, moves each later one up, then the result. Tick: per entry, read,
// multiply, add and compare in the shared due unit; a fired entry waits on a stall.
// One item at a time; ready returns when the last result is registered.
// Reset (arst_n low, asynchronous) empties the table; no clearing pass.
module periodic_timer_table_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// current_time[31:0], timer_unit[34:32], interval[50:35], dest_id[58:51],
	// msg_id[74:59], zero pad
	input  logic [ptt_pkg::IN_DATA_W-1:0]  s_tdata,
	// action[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// fired_dest[7:0], fired_msg[23:8], fired_unit[26:24],
	// fired_interval[42:27], fired_start[74:43], zero pad
	output logic [ptt_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[2:0]
	output logic [2:0]                     m_tuser,
	output logic                           m_tlast
);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD, S_RESP, S_T_RD, S_T_MUL, S_T_CMP,
		S_D_RD, S_D_CHK, S_S_RD, S_S_WR
	} state_t;

	localparam logic [ptt_pkg::CNT_W-1:0] CNT_MAX = ptt_pkg::CNT_W'(ptt_pkg::MAX_TIMERS);

	state_t                     state_q;
	logic [ptt_pkg::CNT_W-1:0]  cnt_q;
	logic [ptt_pkg::CNT_W-1:0]  i_q;
	logic [ptt_pkg::CNT_W-1:0]  i_nxt;
	logic [31:0]                now_q;
	logic [2:0]                 unit_q;
	logic [15:0]                ivl_q;
	logic [7:0]                 dest_q;
	logic [15:0]                msg_q;
	logic [2:0]                 resp_q;
	logic                       m_tvalid_q;
	logic [ptt_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [2:0]                 m_tuser_q;
	logic                       m_tlast_q;

	ptt_pkg::ptt_tbl_req_t      tbl_req;
	ptt_pkg::ptt_entry_t        wr_data;
	ptt_pkg::ptt_entry_t        rd_data;
	logic                       due_hit;
	logic                       out_free;
	logic                       out_load;
	logic                       is_10ms;
	logic                       fire;
	logic                       match;
	logic [31:0]                fired_start;

	assign i_nxt       = i_q + 1'b1;
	assign out_free    = !m_tvalid_q || m_tready;
	assign is_10ms     = rd_data.unit == ptt_pkg::UNIT_10MS;
	assign fire        = is_10ms || due_hit;
	assign out_load    = out_free && ((state_q == S_RESP) || (state_q == S_T_CMP && fire));
	assign fired_start = is_10ms ? rd_data.start : now_q;
	assign match       = rd_data.unit == unit_q && rd_data.dest == dest_q
	                     && rd_data.msg == msg_q;

	always_comb begin
		tbl_req         = '0;
		tbl_req.rd_addr = i_q[ptt_pkg::IDX_W-1:0];
		tbl_req.wr_addr = i_q[ptt_pkg::IDX_W-1:0];
		wr_data         = rd_data;
		unique case (state_q)
			S_ADD: begin
				tbl_req.wr_en   = cnt_q != CNT_MAX;
				tbl_req.wr_addr = cnt_q[ptt_pkg::IDX_W-1:0];
				wr_data         = '{start: now_q, interval: ivl_q, unit: unit_q,
				                    dest: dest_q, msg: msg_q};
			end
			S_T_RD, S_D_RD: begin
				tbl_req.rd_en = 1'b1;
			end
			S_T_CMP: begin
				tbl_req.wr_en = out_free && due_hit && !is_10ms;
				wr_data.start = now_q;
			end
			S_S_RD: begin
				tbl_req.rd_en   = 1'b1;
				tbl_req.rd_addr = i_nxt[ptt_pkg::IDX_W-1:0];
			end
			S_S_WR: begin
				tbl_req.wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	ptt_table u_table (
		.clk     (clk),
		.req     (tbl_req),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	ptt_due u_due (
		.clk      (clk),
		.load     (state_q == S_T_MUL),
		.interval (rd_data.interval),
		.unit     (rd_data.unit),
		.start    (rd_data.start),
		.now      (now_q),
		.hit      (due_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			i_q        <= '0;
			resp_q     <= ptt_pkg::ST_TICK_DONE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						now_q  <= s_tdata[31:0];
						unit_q <= s_tdata[34:32];
						ivl_q  <= s_tdata[50:35];
						dest_q <= s_tdata[58:51];
						msg_q  <= s_tdata[74:59];
						i_q    <= '0;
						unique case (s_tuser)
							ptt_pkg::ACT_TICK: begin
								resp_q  <= ptt_pkg::ST_TICK_DONE;
								state_q <= (cnt_q == '0) ? S_RESP : S_T_RD;
							end
							ptt_pkg::ACT_ADD: begin
								state_q <= S_ADD;
							end
							ptt_pkg::ACT_DEL: begin
								resp_q  <= ptt_pkg::ST_NOT_FOUND;
								state_q <= (cnt_q == '0) ? S_RESP : S_D_RD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ADD: begin
					if (cnt_q == CNT_MAX) begin
						resp_q <= ptt_pkg::ST_FULL;
					end else begin
						resp_q <= ptt_pkg::ST_ADDED;
						cnt_q  <= cnt_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						m_tuser_q  <= resp_q;
						m_tlast_q  <= 1'b1;
						m_tdata_q  <= '0;
						state_q    <= S_IDLE;
					end
				end
				S_T_RD: begin
					state_q <= S_T_MUL;
				end
				S_T_MUL: begin
					state_q <= S_T_CMP;
				end
				S_T_CMP: begin
					if (!fire || out_free) begin
						if (fire) begin
							m_tuser_q  <= ptt_pkg::ST_FIRED;
							m_tlast_q  <= 1'b0;
							m_tdata_q  <= {5'b0, fired_start, rd_data.interval,
							               rd_data.unit, rd_data.msg, rd_data.dest};
						end
						i_q     <= i_nxt;
						state_q <= (i_nxt == cnt_q) ? S_RESP : S_T_RD;
					end
				end
				S_D_RD: begin
					state_q <= S_D_CHK;
				end
				S_D_CHK: begin
					if (match) begin
						if (i_nxt == cnt_q) begin
							cnt_q   <= cnt_q - 1'b1;
							resp_q  <= ptt_pkg::ST_DELETED;
							state_q <= S_RESP;
						end else begin
							state_q <= S_S_RD;
						end
					end else begin
						i_q     <= i_nxt;
						state_q <= (i_nxt == cnt_q) ? S_RESP : S_D_RD;
					end
				end
				S_S_RD: begin
					state_q <= S_S_WR;
				end
				S_S_WR: begin
					i_q <= i_nxt;
					if (i_nxt + 1'b1 == cnt_q) begin
						cnt_q   <= cnt_q - 1'b1;
						resp_q  <= ptt_pkg::ST_DELETED;
						state_q <= S_RESP;
					end else begin
						state_q <= S_S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count above table depth");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_req.wr_en |-> ptt_pkg::CNT_W'(tbl_req.wr_addr) <= cnt_q)
		else $error("table write beyond the filled entries");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != ptt_pkg::ACT_UNUSED |=> !s_tready)
		else $error("new item taken while one is in progress");

	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ptt_pkg::ST_FIRED |-> !m_tlast)
		else $error("fired result marked as final");

endmodule
